// ===== hdl/spd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg: shared constants and types for the steering PID drive
// Widths of the error path, products and drive, register indexes, and the
// structs that carry configuration into the pipeline stages.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int ANGLE_WIDTH    = 16;
    localparam int GAIN_FRAC_BITS = 16;

    localparam int GAIN_W  = 32;
    localparam int ACC_W   = 32;
    localparam int ERR_W   = ANGLE_WIDTH + 1;
    localparam int DE_W    = ANGLE_WIDTH + 2;
    localparam int P_W     = GAIN_W + ERR_W;
    localparam int I_W     = GAIN_W + ACC_W;
    localparam int D_W     = GAIN_W + DE_W;
    localparam int SUM_W   = I_W + 2;
    localparam int Q_W     = SUM_W - GAIN_FRAC_BITS;
    localparam int DRIVE_W = Q_W + 4;
    localparam int DHI_W   = 16;
    localparam int DLO_W   = 17;
    localparam int CLAMP_W = DLO_W + 1;
    localparam int DUTY_W  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int IN_TDATA_W  = 2 * ANGLE_WIDTH;
    localparam int OUT_TDATA_W = ((1 + DUTY_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP       = 3'd0,
        REG_KI       = 3'd1,
        REG_KD       = 3'd2,
        REG_INT_HI   = 3'd3,
        REG_INT_LO   = 3'd4,
        REG_DRIVE_HI = 3'd5,
        REG_DRIVE_LO = 3'd6
    } t_cfg_reg;

    localparam logic signed [ACC_W-1:0] INT_HI_RST = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] INT_LO_RST = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [DHI_W-1:0]        DRIVE_HI_RST = {DHI_W{1'b1}};
    localparam logic signed [DLO_W-1:0] DRIVE_LO_RST = {1'b1, {(DLO_W-2){1'b0}}, 1'b1};

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } t_gains;

    typedef struct packed {
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
    } t_acc_lim;

    typedef struct packed {
        logic [DHI_W-1:0]        hi;
        logic signed [DLO_W-1:0] lo;
    } t_drive_lim;

endpackage
`default_nettype wire

// ===== hdl/spd_error_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_error_stage: input register, error, clamped integral and derivative
// Holds the integral accumulator and previous error; both update when the
// item leaves the input register.
// ----------------------------------------------------------------------------
module spd_error_stage
    import spd_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [ANGLE_WIDTH-1:0] i_target,
    input  wire logic signed [ANGLE_WIDTH-1:0] i_measured,
    input  wire t_acc_lim                      i_lim,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [ERR_W-1:0]            o_err,
    output logic signed [ACC_W-1:0]            o_acc,
    output logic signed [DE_W-1:0]             o_de
);

    logic                          r_in_valid;
    logic signed [ANGLE_WIDTH-1:0] r_target;
    logic signed [ANGLE_WIDTH-1:0] r_measured;
    logic                          r_valid;
    logic signed [ERR_W-1:0]       r_err;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [DE_W-1:0]        r_de;
    logic signed [ACC_W-1:0]       r_error_sum;
    logic signed [ERR_W-1:0]       r_last_error;

    logic                    out_ready;
    logic                    advance;
    logic signed [ERR_W-1:0] n_err;
    logic signed [ACC_W:0]   raw_sum;
    logic signed [ACC_W:0]   hi_ext;
    logic signed [ACC_W:0]   lo_ext;
    logic signed [ACC_W:0]   upper_clip;
    logic signed [ACC_W:0]   lower_clip;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [DE_W-1:0]  n_de;

    assign out_ready = !r_valid || i_ready;
    assign advance   = r_in_valid && out_ready;
    assign o_ready   = !r_in_valid || out_ready;

    always_comb begin
        n_err   = {r_target[ANGLE_WIDTH-1], r_target}
                - {r_measured[ANGLE_WIDTH-1], r_measured};
        raw_sum = {r_error_sum[ACC_W-1], r_error_sum}
                + {{(ACC_W+1-ERR_W){n_err[ERR_W-1]}}, n_err};
        hi_ext  = {i_lim.hi[ACC_W-1], i_lim.hi};
        lo_ext  = {i_lim.lo[ACC_W-1], i_lim.lo};
        // upper bound first, lower bound wins when the limits cross
        upper_clip = (raw_sum > hi_ext) ? hi_ext : raw_sum;
        lower_clip = (upper_clip < lo_ext) ? lo_ext : upper_clip;
        n_acc   = lower_clip[ACC_W-1:0];
        n_de    = {n_err[ERR_W-1], n_err} - {r_last_error[ERR_W-1], r_last_error};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_valid      <= 1'b0;
            r_error_sum  <= '0;
            r_last_error <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_ready) begin
                r_valid <= r_in_valid;
            end
            if (advance) begin
                r_error_sum  <= n_acc;
                r_last_error <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_target   <= i_target;
            r_measured <= i_measured;
        end
        if (advance) begin
            r_err <= n_err;
            r_acc <= n_acc;
            r_de  <= n_de;
        end
    end

    assign o_valid = r_valid;
    assign o_err   = r_err;
    assign o_acc   = r_acc;
    assign o_de    = r_de;

endmodule
`default_nettype wire

// ===== hdl/spd_mul_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_mul_stage: gain multiplies
// Three parallel signed multiplies of the error terms by their gains,
// each product registered.
// ----------------------------------------------------------------------------
module spd_mul_stage
    import spd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic signed [ERR_W-1:0] i_err,
    input  wire logic signed [ACC_W-1:0] i_acc,
    input  wire logic signed [DE_W-1:0]  i_de,
    input  wire t_gains                  i_gains,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [P_W-1:0]        o_p_term,
    output logic signed [I_W-1:0]        o_i_term,
    output logic signed [D_W-1:0]        o_d_term
);

    logic                  r_valid;
    logic signed [P_W-1:0] r_p_term;
    logic signed [I_W-1:0] r_i_term;
    logic signed [D_W-1:0] r_d_term;
    logic signed [P_W-1:0] n_p_term;
    logic signed [I_W-1:0] n_i_term;
    logic signed [D_W-1:0] n_d_term;
    logic signed [P_W-1:0] kp_x;
    logic signed [P_W-1:0] err_x;
    logic signed [I_W-1:0] ki_x;
    logic signed [I_W-1:0] acc_x;
    logic signed [D_W-1:0] kd_x;
    logic signed [D_W-1:0] de_x;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // sign-extend each operand to its full product width
        kp_x  = {{(P_W-GAIN_W){i_gains.kp[GAIN_W-1]}}, i_gains.kp};
        err_x = {{(P_W-ERR_W){i_err[ERR_W-1]}}, i_err};
        ki_x  = {{(I_W-GAIN_W){i_gains.ki[GAIN_W-1]}}, i_gains.ki};
        acc_x = {{(I_W-ACC_W){i_acc[ACC_W-1]}}, i_acc};
        kd_x  = {{(D_W-GAIN_W){i_gains.kd[GAIN_W-1]}}, i_gains.kd};
        de_x  = {{(D_W-DE_W){i_de[DE_W-1]}}, i_de};
        n_p_term = kp_x * err_x;
        n_i_term = ki_x * acc_x;
        n_d_term = kd_x * de_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_p_term <= n_p_term;
            r_i_term <= n_i_term;
            r_d_term <= n_d_term;
        end
    end

    assign o_valid  = r_valid;
    assign o_p_term = r_p_term;
    assign o_i_term = r_i_term;
    assign o_d_term = r_d_term;

endmodule
`default_nettype wire

// ===== hdl/spd_sum_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_sum_stage: term sum, scale-down and amplification
// Sums the three products, drops the fraction with truncation toward zero,
// then multiplies by ten; one register after each step.
// ----------------------------------------------------------------------------
module spd_sum_stage
    import spd_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [P_W-1:0]     i_p_term,
    input  wire logic signed [I_W-1:0]     i_i_term,
    input  wire logic signed [D_W-1:0]     i_d_term,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed [DRIVE_W-1:0]      o_drive
);

    logic                      r_sum_valid;
    logic                      r_q_valid;
    logic                      r_drive_valid;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [Q_W-1:0]     r_q;
    logic signed [DRIVE_W-1:0] r_drive;

    logic                      drive_ready;
    logic                      q_ready;
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [SUM_W-1:0]   biased;
    logic signed [Q_W-1:0]     n_q;
    logic signed [DRIVE_W-1:0] q_ext;
    logic signed [DRIVE_W-1:0] n_drive;

    assign drive_ready = !r_drive_valid || i_ready;
    assign q_ready     = !r_q_valid || drive_ready;
    assign o_ready     = !r_sum_valid || q_ready;

    always_comb begin
        n_sum  = {{(SUM_W-P_W){i_p_term[P_W-1]}}, i_p_term}
               + {{(SUM_W-I_W){i_i_term[I_W-1]}}, i_i_term}
               + {{(SUM_W-D_W){i_d_term[D_W-1]}}, i_d_term};
        // bias negative sums so the floor shift truncates toward zero
        biased = r_sum + {{(SUM_W-GAIN_FRAC_BITS){1'b0}},
                          {GAIN_FRAC_BITS{r_sum[SUM_W-1]}}};
        n_q    = biased[SUM_W-1:GAIN_FRAC_BITS];
        q_ext  = {{(DRIVE_W-Q_W){r_q[Q_W-1]}}, r_q};
        n_drive = (q_ext <<< 3) + (q_ext <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid   <= 1'b0;
            r_q_valid     <= 1'b0;
            r_drive_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_sum_valid <= i_valid;
            end
            if (q_ready) begin
                r_q_valid <= r_sum_valid;
            end
            if (drive_ready) begin
                r_drive_valid <= r_q_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_sum <= n_sum;
        end
        if (r_sum_valid && q_ready) begin
            r_q <= n_q;
        end
        if (r_q_valid && drive_ready) begin
            r_drive <= n_drive;
        end
    end

    assign o_valid = r_drive_valid;
    assign o_drive = r_drive;

endmodule
`default_nettype wire

// ===== hdl/spd_drive_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_drive_stage: drive saturation and output register
// Clamps the amplified drive to the drive limits and splits it into a
// direction bit and a duty magnitude.
// ----------------------------------------------------------------------------
module spd_drive_stage
    import spd_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [DRIVE_W-1:0] i_drive,
    input  wire t_drive_lim                i_lim,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic                           o_forward,
    output logic [DUTY_W-1:0]              o_duty
);

    logic              r_valid;
    logic              r_forward;
    logic [DUTY_W-1:0] r_duty;

    logic signed [DRIVE_W-1:0] hi_ext;
    logic signed [DRIVE_W-1:0] lo_ext;
    logic signed [DRIVE_W-1:0] upper_clip;
    logic signed [DRIVE_W-1:0] lower_clip;
    logic signed [CLAMP_W-1:0] clamped;
    logic [CLAMP_W-1:0]        neg_mag;
    logic                      n_forward;
    logic [DUTY_W-1:0]         n_duty;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        hi_ext     = {{(DRIVE_W-DHI_W){1'b0}}, i_lim.hi};
        lo_ext     = {{(DRIVE_W-DLO_W){i_lim.lo[DLO_W-1]}}, i_lim.lo};
        upper_clip = (i_drive > hi_ext) ? hi_ext : i_drive;
        lower_clip = (upper_clip < lo_ext) ? lo_ext : upper_clip;
        clamped    = lower_clip[CLAMP_W-1:0];
        neg_mag    = -clamped;
        n_forward  = !clamped[CLAMP_W-1];
        if (n_forward) begin
            n_duty = clamped[DUTY_W-1:0];
        end else if (|neg_mag[CLAMP_W-1:DUTY_W]) begin
            // full-scale reverse drive saturates the duty
            n_duty = {DUTY_W{1'b1}};
        end else begin
            n_duty = neg_mag[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_forward <= n_forward;
            r_duty    <= n_duty;
        end
    end

    assign o_valid   = r_valid;
    assign o_forward = r_forward;
    assign o_duty    = r_duty;

endmodule
`default_nettype wire

// ===== hdl/steering_pid_pwm_drive_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// steering_pid_pwm_drive_top: steering PID controller with PWM drive output
// Pipeline: input register, error register, product register, then the sum, quotient, drive and output registers.
// Throughput: one transaction per cycle; each stage stalls only on a full
// stage behind it, so bubbles absorb output back-pressure.
// Reset (synchronous, active low) clears the integral and previous error,
// empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module steering_pid_pwm_drive_top
    import spd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // config write port
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // input stream
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [15:0] target_angle, [31:16] measured_angle
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // output stream
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [0] forward, [16:1] duty, [23:17] zero
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    logic signed [GAIN_W-1:0] r_kp;
    logic signed [GAIN_W-1:0] r_ki;
    logic signed [GAIN_W-1:0] r_kd;
    logic signed [ACC_W-1:0]  r_int_hi;
    logic signed [ACC_W-1:0]  r_int_lo;
    logic [DHI_W-1:0]         r_drive_hi;
    logic signed [DLO_W-1:0]  r_drive_lo;

    t_gains     gains;
    t_acc_lim   acc_lim;
    t_drive_lim drive_lim;

    logic                    err_valid;
    logic                    mul_ready;
    logic signed [ERR_W-1:0] err;
    logic signed [ACC_W-1:0] acc;
    logic signed [DE_W-1:0]  de;

    logic                    mul_valid;
    logic                    sum_ready;
    logic signed [P_W-1:0]   p_term;
    logic signed [I_W-1:0]   i_term;
    logic signed [D_W-1:0]   d_term;

    logic                      sum_valid;
    logic                      drv_ready;
    logic signed [DRIVE_W-1:0] drive;

    logic              forward;
    logic [DUTY_W-1:0] duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= '0;
            r_ki       <= '0;
            r_kd       <= '0;
            r_int_hi   <= INT_HI_RST;
            r_int_lo   <= INT_LO_RST;
            r_drive_hi <= DRIVE_HI_RST;
            r_drive_lo <= DRIVE_LO_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_KP:       r_kp       <= i_cfg_wdata[GAIN_W-1:0];
                REG_KI:       r_ki       <= i_cfg_wdata[GAIN_W-1:0];
                REG_KD:       r_kd       <= i_cfg_wdata[GAIN_W-1:0];
                REG_INT_HI:   r_int_hi   <= i_cfg_wdata[ACC_W-1:0];
                REG_INT_LO:   r_int_lo   <= i_cfg_wdata[ACC_W-1:0];
                REG_DRIVE_HI: r_drive_hi <= i_cfg_wdata[DHI_W-1:0];
                REG_DRIVE_LO: r_drive_lo <= i_cfg_wdata[DLO_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign gains     = '{kp: r_kp, ki: r_ki, kd: r_kd};
    assign acc_lim   = '{hi: r_int_hi, lo: r_int_lo};
    assign drive_lim = '{hi: r_drive_hi, lo: r_drive_lo};

    spd_error_stage u_error (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_target   (i_s_axis_tdata[ANGLE_WIDTH-1:0]),
        .i_measured (i_s_axis_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]),
        .i_lim      (acc_lim),
        .o_valid    (err_valid),
        .i_ready    (mul_ready),
        .o_err      (err),
        .o_acc      (acc),
        .o_de       (de)
    );

    spd_mul_stage u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (err_valid),
        .o_ready  (mul_ready),
        .i_err    (err),
        .i_acc    (acc),
        .i_de     (de),
        .i_gains  (gains),
        .o_valid  (mul_valid),
        .i_ready  (sum_ready),
        .o_p_term (p_term),
        .o_i_term (i_term),
        .o_d_term (d_term)
    );

    spd_sum_stage u_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (mul_valid),
        .o_ready  (sum_ready),
        .i_p_term (p_term),
        .i_i_term (i_term),
        .i_d_term (d_term),
        .o_valid  (sum_valid),
        .i_ready  (drv_ready),
        .o_drive  (drive)
    );

    spd_drive_stage u_drive (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (sum_valid),
        .o_ready   (drv_ready),
        .i_drive   (drive),
        .i_lim     (drive_lim),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_forward (forward),
        .o_duty    (duty)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-DUTY_W-1){1'b0}}, duty, forward};

endmodule
`default_nettype wire

// ===== tb/spd_drive_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_drive_checker: drive command checker for the steering PID block
// Watches the register port and both streams. Every accepted control tick is
// run through a local PID model to get the expected forward/duty pair, and
// every accepted drive transaction is compared against the oldest one queued.
// ----------------------------------------------------------------------------
module spd_drive_checker
    import spd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                   i_tick_valid,
    input  wire logic                   i_tick_ready,
    // [15:0] target_angle, [31:16] measured_angle
    input  wire logic [IN_TDATA_W-1:0]  i_tick_data,
    input  wire logic                   i_drive_valid,
    input  wire logic                   i_drive_ready,
    // [0] forward, [16:1] duty, [23:17] zero
    input  wire logic [OUT_TDATA_W-1:0] i_drive_data,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        logic              forward;
        logic [DUTY_W-1:0] duty;
    } t_drive_cmd;

    logic signed [GAIN_W-1:0] kp_q;
    logic signed [GAIN_W-1:0] ki_q;
    logic signed [GAIN_W-1:0] kd_q;
    logic signed [ACC_W-1:0]  acc_max;
    logic signed [ACC_W-1:0]  acc_min;
    logic [DHI_W-1:0]         drive_max;
    logic signed [DLO_W-1:0]  drive_min;
    logic signed [ACC_W-1:0]  err_total;
    logic signed [ERR_W-1:0]  prev_err;
    t_drive_cmd               drive_q[$];
    int                       fail_count = 0;

    // Advance the controller state by one tick and return the drive command.
    function automatic t_drive_cmd next_drive(input logic signed [ANGLE_WIDTH-1:0] target,
                                              input logic signed [ANGLE_WIDTH-1:0] measured);
        longint     err;
        longint     acc;
        longint     sum;
        longint     q;
        longint     drive;
        t_drive_cmd cmd;
        err = longint'(target) - longint'(measured);
        acc = longint'(err_total) + err;
        // upper clamp first, so inverted limits settle on the lower one
        if (acc > longint'(acc_max)) acc = longint'(acc_max);
        if (acc < longint'(acc_min)) acc = longint'(acc_min);
        sum = longint'(kp_q) * err + longint'(ki_q) * acc
            + longint'(kd_q) * (err - longint'(prev_err));
        // drop the fraction, truncating toward zero
        q = (sum < 0) ? -((-sum) >>> GAIN_FRAC_BITS) : (sum >>> GAIN_FRAC_BITS);
        drive = q * 10;
        if (drive > longint'(drive_max)) drive = longint'(drive_max);
        if (drive < longint'(drive_min)) drive = longint'(drive_min);
        cmd.forward = (drive >= 0);
        if (drive < 0) drive = -drive;
        cmd.duty = (drive > longint'({DUTY_W{1'b1}})) ? {DUTY_W{1'b1}} : DUTY_W'(drive);
        err_total = ACC_W'(acc);
        prev_err  = ERR_W'(err);
        return cmd;
    endfunction

    always @(posedge i_clk) begin : watch
        t_drive_cmd want;
        t_drive_cmd got;
        if (!i_rst_n) begin
            kp_q      = '0;
            ki_q      = '0;
            kd_q      = '0;
            acc_max   = INT_HI_RST;
            acc_min   = INT_LO_RST;
            drive_max = DRIVE_HI_RST;
            drive_min = DRIVE_LO_RST;
            err_total = '0;
            prev_err  = '0;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KP:       kp_q      = i_cfg_wdata;
                    REG_KI:       ki_q      = i_cfg_wdata;
                    REG_KD:       kd_q      = i_cfg_wdata;
                    REG_INT_HI:   acc_max   = i_cfg_wdata;
                    REG_INT_LO:   acc_min   = i_cfg_wdata;
                    REG_DRIVE_HI: drive_max = i_cfg_wdata[DHI_W-1:0];
                    REG_DRIVE_LO: drive_min = i_cfg_wdata[DLO_W-1:0];
                    default: ;
                endcase
            end
            if (i_drive_valid && i_drive_ready) begin
                got.forward = i_drive_data[0];
                got.duty    = i_drive_data[DUTY_W:1];
                if (drive_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: drive transaction with nothing expected: forward %0d duty %0d",
                                 $realtime, got.forward, got.duty);
                    fail_count++;
                end else begin
                    want = drive_q.pop_front();
                    if (got.forward !== want.forward || got.duty !== want.duty) begin
                        if (fail_count < 10)
                            $display("%0t: drive mismatch: expected forward %0d duty %0d, got forward %0d duty %0d",
                                     $realtime, want.forward, want.duty, got.forward, got.duty);
                        fail_count++;
                    end
                end
            end
            if (i_tick_valid && i_tick_ready)
                drive_q.push_back(next_drive(i_tick_data[ANGLE_WIDTH-1:0],
                                             i_tick_data[IN_TDATA_W-1:ANGLE_WIDTH]));
        end
        o_pending    = drive_q.size();
        o_fail_count = fail_count;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for steering_pid_pwm_drive_top
// Loads several gain and limit settings over the register port, sends
// directed and random control ticks under varying source idling and sink
// back-pressure, and reports the checker's result.
// ----------------------------------------------------------------------------
module tb_top;
    import spd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;  // unmapped index
    localparam int RANDOM_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 143;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data    = '0;
    logic                   m_ready   = 1'b0;
    wire                    s_ready;
    wire                    m_valid;
    wire [OUT_TDATA_W-1:0]  m_data;
    int                     idle_pct  = 0;
    int                     stall_pct = 0;
    int                     fail_count;
    int                     pending;

    steering_pid_pwm_drive_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    spd_drive_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .i_tick_valid  (s_valid),
        .i_tick_ready  (s_ready),
        .i_tick_data   (s_data),
        .i_drive_valid (m_valid),
        .i_drive_ready (m_ready),
        .i_drive_data  (m_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    // Hold valid across back-to-back ticks; the caller drops it when done.
    task automatic send_tick(input logic signed [ANGLE_WIDTH-1:0] target,
                             input logic signed [ANGLE_WIDTH-1:0] measured);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {measured, target};
        do @(posedge clk); while (!s_ready);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] rand_gain();
        logic [GAIN_W-1:0] g;
        case ($urandom_range(4))
            0:       g = $urandom_range(32'h0004_0000);
            1:       g = $urandom_range(32'h0000_1000);
            2:       g = $urandom;
            3:       g = '0;
            default: g = $urandom_range(32'h0001_0000);
        endcase
        if ($urandom_range(1)) g = -g;
        return g;
    endfunction

    function automatic int extreme_angle();
        case ($urandom_range(3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    initial begin
        int                phase;
        int                pick;
        int                t;
        int                m;
        logic [ACC_W-1:0]  ilim;
        logic [ACC_W-1:0]  acc_hi;
        logic [ACC_W-1:0]  acc_lo;
        logic [DLO_W-1:0]  dlo;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unit proportional gain, light integral and derivative, tight windup clamp
        write_reg(REG_KP, 32'h0001_0000);
        write_reg(REG_KI, 32'h0000_0100);
        write_reg(REG_KD, 32'h0000_8000);
        write_reg(REG_INT_HI, 32'sd100000);
        write_reg(REG_INT_LO, -32'sd100000);
        cfg_we <= 1'b0;
        send_tick(16'sd0, 16'sd0);
        send_tick(16'sh7FFF, 16'sh8000);
        send_tick(16'sh7FFF, 16'sh8000);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(-16'sd1, 16'sd0);
        send_tick(16'sd1, 16'sd0);
        send_tick(16'sd100, 16'sd100);

        // inverted integral and drive limits, extreme gains
        wait_idle();
        write_reg(REG_KP, 32'h7FFF_FFFF);
        write_reg(REG_KI, 32'h8000_0000);
        write_reg(REG_KD, 32'hFFFF_FFFF);
        write_reg(REG_INT_HI, -32'sd5);
        write_reg(REG_INT_LO, 32'sd5);
        write_reg(REG_DRIVE_HI, 32'd100);
        write_reg(REG_DRIVE_LO, 32'd200);
        cfg_we <= 1'b0;
        send_tick(16'sd5, -16'sd3);
        send_tick(-16'sd7, 16'sd9);
        send_tick(16'sh7FFF, 16'sh8000);
        send_tick(16'sd0, 16'sd0);

        // full negative drive range: duty pins at its maximum in reverse
        wait_idle();
        write_reg(REG_KP, 32'h8000_0000);
        write_reg(REG_KI, 32'h0000_0000);
        write_reg(REG_KD, 32'h0000_0000);
        write_reg(REG_INT_HI, 32'h7FFF_FFFF);
        write_reg(REG_INT_LO, 32'h8000_0000);
        write_reg(REG_DRIVE_HI, 32'hFFFF_FFFF);
        write_reg(REG_DRIVE_LO, 32'hFFFF_0000);
        write_reg(REG_NONE, 32'hA5A5_5A5A);
        cfg_we <= 1'b0;
        send_tick(16'sh7FFF, 16'sh8000);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(16'sd3, 16'sd2);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            idle_pct  = 0;
            stall_pct = 0;
            if (phase == 0) begin
                write_reg(REG_KP, 32'h7FFF_FFFF);
                write_reg(REG_KI, 32'h7FFF_FFFF);
                write_reg(REG_KD, 32'h7FFF_FFFF);
                write_reg(REG_INT_HI, 32'h7FFF_FFFF);
                write_reg(REG_INT_LO, 32'h8000_0000);
                write_reg(REG_DRIVE_HI, 32'h0000_FFFF);
                write_reg(REG_DRIVE_LO, 32'h0001_0000);
            end else if (phase == 1) begin
                write_reg(REG_KP, 32'h8000_0000);
                write_reg(REG_KI, 32'h8000_0000);
                write_reg(REG_KD, 32'h8000_0000);
                write_reg(REG_INT_HI, 32'h8000_0000);
                write_reg(REG_INT_LO, 32'h7FFF_FFFF);
                write_reg(REG_DRIVE_HI, 32'h0000_0000);
                write_reg(REG_DRIVE_LO, 32'h0000_0000);
            end else begin
                write_reg(REG_KP, rand_gain());
                write_reg(REG_KI, rand_gain());
                write_reg(REG_KD, rand_gain());
                case ($urandom_range(3))
                    0: begin
                        acc_hi = INT_HI_RST;
                        acc_lo = INT_LO_RST;
                    end
                    1: begin
                        ilim   = $urandom_range(300000, 1);
                        acc_hi = ilim;
                        acc_lo = -ilim;
                    end
                    2: begin
                        ilim   = $urandom_range(5000, 1);
                        acc_hi = -ilim;
                        acc_lo = ilim;
                    end
                    default: begin
                        acc_hi = $urandom;
                        acc_lo = $urandom;
                    end
                endcase
                write_reg(REG_INT_HI, acc_hi);
                write_reg(REG_INT_LO, acc_lo);
                // junk above the field width must be dropped
                write_reg(REG_DRIVE_HI, {16'($urandom), 16'($urandom_range(65535))});
                if ($urandom_range(7) == 0)
                    dlo = 17'($urandom_range(2000));
                else
                    dlo = 17'(-$urandom_range(65536));
                write_reg(REG_DRIVE_LO, {15'($urandom), dlo});
            end
            write_reg(REG_NONE, $urandom);
            cfg_we <= 1'b0;

            case (phase % 4)
                1: idle_pct = 45;
                2: stall_pct = 45;
                3: begin
                    idle_pct  = 37;
                    stall_pct = 37;
                end
                default: ;
            endcase

            repeat (TICKS_PER_PHASE) begin
                pick = $urandom_range(99);
                t    = $urandom_range(65535) - 32768;
                if (pick < 60) begin
                    // track: measured angle close to the target
                    m = t + $urandom_range(400) - 200;
                    if (m > 32767) m = 32767;
                    if (m < -32768) m = -32768;
                end else if (pick < 85) begin
                    m = $urandom_range(65535) - 32768;
                end else begin
                    t = extreme_angle();
                    m = extreme_angle();
                end
                send_tick(ANGLE_WIDTH'(t), ANGLE_WIDTH'(m));
            end
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("steering_pid_pwm_drive_top test passed");
        else
            $display("steering_pid_pwm_drive_top test failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("steering_pid_pwm_drive_top test failed");
        $finish;
    end

endmodule
